[design/sld_pkg.sv]
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the shortest line dispatcher.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Field widths
    localparam int LINE_W      = 4;
    localparam int COUNT_W     = 16;
    localparam int TOTAL_W     = 20;
    localparam int PEOPLE_W    = 19;
    localparam int OP_W        = 3;
    localparam int CFG_W       = 19;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_LINES_W = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_JOIN_SHORTEST = 3'd0;
    localparam logic [OP_W-1:0] OP_JOIN_LINE     = 3'd1;
    localparam logic [OP_W-1:0] OP_LEAVE_LINE    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_COUNT     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL     = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY         = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LINES = 1'b1;

    localparam logic [COUNT_W-1:0]     COUNT_CEIL      = 16'hFFFF;
    localparam logic [NUM_LINES_W-1:0] NUM_LINES_RESET = 4'd8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EXEC,
        ST_FINISH
    } state_t;

endpackage

[design/sld_req_if.sv]
// ----------------------------------------------------------------------------
// sld_req_if
// Request channel: one dispatcher operation per request.
// ----------------------------------------------------------------------------
interface sld_req_if;
    logic                          valid;
    logic                          ready;
    logic [sld_pkg::OP_W-1:0]      operation;
    logic [sld_pkg::LINE_W-1:0]    line_number;
    logic signed [sld_pkg::COUNT_W-1:0] new_count;

    modport source (
        output valid, operation, line_number, new_count,
        input  ready
    );
    modport sink (
        input  valid, operation, line_number, new_count,
        output ready
    );
endinterface

[design/sld_rsp_if.sv]
// ----------------------------------------------------------------------------
// sld_rsp_if
// Result channel: status and counts after each request.
// ----------------------------------------------------------------------------
interface sld_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [sld_pkg::LINE_W-1:0]      line_affected;
    logic [sld_pkg::COUNT_W-1:0]     line_count;
    logic [sld_pkg::PEOPLE_W-1:0]    total_people;
    logic [sld_pkg::LINE_W-1:0]      next_line;
    logic                            is_full;
    logic                            is_empty;

    modport source (
        output valid, ok, line_affected, line_count, total_people, next_line,
               is_full, is_empty,
        input  ready
    );
    modport sink (
        input  valid, ok, line_affected, line_count, total_people, next_line,
               is_full, is_empty,
        output ready
    );
endinterface

[design/sld_ram.sv]
// ----------------------------------------------------------------------------
// sld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/shortest_line_dispatcher.sv]
// ----------------------------------------------------------------------------
// shortest_line_dispatcher
// Per-line people counts in a small RAM with a running total; joins the
// shortest line, joins/leaves/sets/queries a given line, clears all lines.
// ----------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  req     | in        | valid/ready   | operation, line_number, new_count
//  rsp     | out       | valid/ready   | ok, line_affected, line_count,
//          |           |               | total_people, next_line, is_full,
//          |           |               | is_empty
//  cfg     | in        | cfg_we        | cfg_index, cfg_data
//
// One request at a time. The least-count search walks the counts one per cycle
// through the RAM's single read port, once after every update and once more
// before a join-shortest picks its line. A finished result waits in the output
// register while the next request is taken. After reset, per-line valid bits
// make every count read as zero, so no clearing pass is needed; clear-all drops
// the valid bits together in its execute step.
// ----------------------------------------------------------------------------
module shortest_line_dispatcher #(
    parameter int MAX_LINES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sld_req_if.sink                           req,
    sld_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sld_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam logic [sld_pkg::LINE_W-1:0] MAX_LINES_C = sld_pkg::LINE_W'(MAX_LINES);
    localparam int SCAN_W = sld_pkg::LINE_W + 1;

    // Configuration
    logic [sld_pkg::CFG_W-1:0]       max_total_reg;
    logic [sld_pkg::NUM_LINES_W-1:0] num_lines_reg;
    logic [sld_pkg::LINE_W-1:0]      n_use;

    // Sequencer and request
    sld_pkg::state_t                 state_reg, state_next;
    logic [sld_pkg::OP_W-1:0]        op_reg;
    logic [sld_pkg::COUNT_W-1:0]     nc_reg;
    logic [sld_pkg::LINE_W-1:0]      tgt_reg;

    // Count store
    logic [MAX_LINES-1:0]            valid_reg;
    logic [sld_pkg::TOTAL_W-1:0]     total_reg;
    logic                            vld_q_reg;
    logic [sld_pkg::COUNT_W-1:0]     ram_q;
    logic                            ram_re;
    logic [IDX_W-1:0]                ram_raddr;
    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    logic [sld_pkg::LINE_W-1:0]      rd_line;
    logic [sld_pkg::LINE_W-1:0]      rd_line_m1;
    logic [sld_pkg::LINE_W-1:0]      wr_line_m1;
    logic [sld_pkg::COUNT_W-1:0]     cur;

    // Least-count search
    logic [SCAN_W-1:0]               scan_line_reg;
    logic                            scan_post_reg;
    logic                            rd_pend_reg;
    logic [sld_pkg::LINE_W-1:0]      rd_line_reg;
    logic [sld_pkg::LINE_W-1:0]      best_line_reg;
    logic [sld_pkg::COUNT_W-1:0]     best_cnt_reg;
    logic                            scan_issue;
    logic                            scan_done;

    // Update step
    logic                            full;
    logic                            tgt_ok;
    logic [sld_pkg::COUNT_W-1:0]     new_cnt;
    logic [sld_pkg::COUNT_W-1:0]     set_val;
    logic [sld_pkg::TOTAL_W-1:0]     total_calc;
    logic                            ok_calc;
    logic                            clear_calc;
    logic                            res_ok_reg;
    logic [sld_pkg::COUNT_W-1:0]     res_count_reg;

    // Handshakes
    logic                            req_fire;
    logic                            exec_en;
    logic                            out_load;
    logic                            ln_valid;
    logic                            op_takes_line;

    // Output register
    logic                            out_valid_reg;
    logic                            out_ok_reg;
    logic [sld_pkg::LINE_W-1:0]      out_line_reg;
    logic [sld_pkg::COUNT_W-1:0]     out_count_reg;
    logic [sld_pkg::PEOPLE_W-1:0]    out_total_reg;
    logic [sld_pkg::LINE_W-1:0]      out_next_reg;
    logic                            out_full_reg;
    logic                            out_empty_reg;

    // Lines in use, clamped to 1..MAX_LINES
    always_comb
    begin
        if (num_lines_reg == '0)
        begin
            n_use = sld_pkg::LINE_W'(1);
        end
        else if (num_lines_reg > MAX_LINES_C)
        begin
            n_use = MAX_LINES_C;
        end
        else
        begin
            n_use = num_lines_reg;
        end
    end

    assign ln_valid      = (req.line_number != '0) && (req.line_number <= n_use);
    assign op_takes_line = (req.operation == sld_pkg::OP_JOIN_LINE)  ||
                           (req.operation == sld_pkg::OP_LEAVE_LINE) ||
                           (req.operation == sld_pkg::OP_SET_COUNT)  ||
                           (req.operation == sld_pkg::OP_QUERY);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sld_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.operation == sld_pkg::OP_JOIN_SHORTEST) ?
                                 sld_pkg::ST_SCAN : sld_pkg::ST_READ;
                end
            end
            sld_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = scan_post_reg ? sld_pkg::ST_FINISH : sld_pkg::ST_READ;
                end
            end
            sld_pkg::ST_READ:   state_next = sld_pkg::ST_EXEC;
            sld_pkg::ST_EXEC:   state_next = sld_pkg::ST_SCAN;
            sld_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = sld_pkg::ST_IDLE;
                end
            end
            default:            state_next = sld_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_fire   = (state_reg == sld_pkg::ST_IDLE) && req.valid;
        scan_issue = (state_reg == sld_pkg::ST_SCAN) && (scan_line_reg <= {1'b0, n_use});
        scan_done  = (state_reg == sld_pkg::ST_SCAN) && !scan_issue && !rd_pend_reg;
        exec_en    = (state_reg == sld_pkg::ST_EXEC);
        ram_re     = scan_issue || (state_reg == sld_pkg::ST_READ);
        out_load   = (state_reg == sld_pkg::ST_FINISH) && (!out_valid_reg || rsp.ready);
        if (state_reg == sld_pkg::ST_SCAN)
        begin
            rd_line = scan_line_reg[sld_pkg::LINE_W-1:0];
        end
        else if (tgt_reg != '0)
        begin
            rd_line = tgt_reg;
        end
        else
        begin
            rd_line = sld_pkg::LINE_W'(1);
        end
    end

    assign req.ready = (state_reg == sld_pkg::ST_IDLE);

    // RAM addressing: line numbers start at 1
    assign rd_line_m1 = rd_line - sld_pkg::LINE_W'(1);
    assign wr_line_m1 = tgt_reg - sld_pkg::LINE_W'(1);
    assign ram_raddr  = rd_line_m1[IDX_W-1:0];
    assign ram_waddr  = wr_line_m1[IDX_W-1:0];
    assign cur        = vld_q_reg ? ram_q : '0;

    sld_ram #(
        .WIDTH (sld_pkg::COUNT_W),
        .DEPTH (MAX_LINES),
        .AW    (IDX_W)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (new_cnt),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Update of the target line and the total
    assign full    = (max_total_reg != '0) && (total_reg >= {1'b0, max_total_reg});
    assign tgt_ok  = (tgt_reg != '0);
    assign set_val = nc_reg[sld_pkg::COUNT_W-1] ? '0 : nc_reg;

    always_comb
    begin
        new_cnt    = cur;
        total_calc = total_reg;
        ok_calc    = 1'b0;
        clear_calc = 1'b0;
        ram_we     = 1'b0;
        unique case (op_reg)
            sld_pkg::OP_JOIN_SHORTEST, sld_pkg::OP_JOIN_LINE:
            begin
                if (tgt_ok && !full && (cur != sld_pkg::COUNT_CEIL))
                begin
                    new_cnt    = cur + sld_pkg::COUNT_W'(1);
                    total_calc = total_reg + sld_pkg::TOTAL_W'(1);
                    ok_calc    = 1'b1;
                    ram_we     = exec_en;
                end
            end
            sld_pkg::OP_LEAVE_LINE:
            begin
                if (tgt_ok && (cur != '0))
                begin
                    new_cnt    = cur - sld_pkg::COUNT_W'(1);
                    total_calc = total_reg - sld_pkg::TOTAL_W'(1);
                    ok_calc    = 1'b1;
                    ram_we     = exec_en;
                end
            end
            sld_pkg::OP_SET_COUNT:
            begin
                if (tgt_ok)
                begin
                    new_cnt    = set_val;
                    total_calc = total_reg - {4'b0, cur} + {4'b0, set_val};
                    ok_calc    = 1'b1;
                    ram_we     = exec_en;
                end
            end
            sld_pkg::OP_CLEAR_ALL:
            begin
                total_calc = '0;
                ok_calc    = 1'b1;
                clear_calc = 1'b1;
            end
            sld_pkg::OP_QUERY:
            begin
                ok_calc = tgt_ok;
            end
            default:
            begin
                ok_calc = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sld_pkg::ST_IDLE;
            max_total_reg <= '0;
            num_lines_reg <= sld_pkg::NUM_LINES_RESET;
            valid_reg     <= '0;
            total_reg     <= '0;
            scan_line_reg <= '0;
            scan_post_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sld_pkg::CFG_MAX_TOTAL: max_total_reg <= cfg_data;
                    sld_pkg::CFG_NUM_LINES:
                        num_lines_reg <= cfg_data[sld_pkg::NUM_LINES_W-1:0];
                    default:                max_total_reg <= max_total_reg;
                endcase
            end

            // Search counter
            if (req_fire || exec_en)
            begin
                scan_line_reg <= SCAN_W'(1);
                scan_post_reg <= exec_en;
            end
            else if (scan_issue)
            begin
                scan_line_reg <= scan_line_reg + SCAN_W'(1);
            end
            rd_pend_reg <= scan_issue;

            // Store update
            if (exec_en)
            begin
                total_reg <= total_calc;
                if (clear_calc)
                begin
                    valid_reg <= '0;
                end
                else if (ram_we)
                begin
                    valid_reg[ram_waddr] <= 1'b1;
                end
            end

            // Output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.operation;
            nc_reg  <= req.new_count;
            tgt_reg <= (op_takes_line && ln_valid) ? req.line_number : '0;
        end
        else if (scan_done && !scan_post_reg)
        begin
            tgt_reg <= best_line_reg;
        end

        if (ram_re)
        begin
            vld_q_reg <= valid_reg[ram_raddr];
        end
        rd_line_reg <= rd_line;

        // Running minimum, ties keep the lower line
        if ((state_reg == sld_pkg::ST_SCAN) && rd_pend_reg)
        begin
            if ((rd_line_reg == sld_pkg::LINE_W'(1)) || (cur < best_cnt_reg))
            begin
                best_line_reg <= rd_line_reg;
                best_cnt_reg  <= cur;
            end
        end

        if (exec_en)
        begin
            res_ok_reg    <= ok_calc;
            res_count_reg <= tgt_ok ? new_cnt : '0;
        end

        if (out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_line_reg  <= tgt_reg;
            out_count_reg <= res_count_reg;
            out_total_reg <= total_reg[sld_pkg::PEOPLE_W-1:0];
            out_next_reg  <= best_line_reg;
            out_full_reg  <= full;
            out_empty_reg <= (total_reg == '0);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.line_affected = out_line_reg;
    assign rsp.line_count    = out_count_reg;
    assign rsp.total_people  = out_total_reg;
    assign rsp.next_line     = out_next_reg;
    assign rsp.is_full       = out_full_reg;
    assign rsp.is_empty      = out_empty_reg;

`ifndef SYNTHESIS
    // Chosen line is always a real line
    a_next_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.next_line != '0) && (rsp.next_line <= MAX_LINES_C))
        else $error("next_line outside the line range");

    // No affected line means no count reported
    a_no_line_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.line_affected == '0)) |-> (rsp.line_count == '0))
        else $error("count reported without a line");

    // One request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    // Search never compares a line outside those in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sld_pkg::ST_SCAN) && rd_pend_reg) |->
            (rd_line_reg != '0) && (rd_line_reg <= n_use))
        else $error("search read a line outside the lines in use");
`endif

endmodule
